FILE: src/scl_pkg.sv
// ============================================================================
// scl_pkg
// Shared types and fixed constants of the sine/cosine table interpolator.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package scl_pkg;

  // Field widths
  localparam int ANGLE_W = 32;
  localparam int VALUE_W = 18;
  localparam int FRAC_W  = 16;

  // Angle period in Q16.16: 2*pi*65536, truncated
  localparam longint unsigned PERIOD = 64'd411774;
  localparam int              A_W    = $clog2(PERIOD);

  // Offset-binary angle plus WRAP_OFFS equals angle + k*PERIOD, never negative
  localparam int              U_W       = ANGLE_W + 1;
  localparam longint unsigned WRAP_K    = ((64'd1 << (ANGLE_W - 1)) + PERIOD - 64'd1) / PERIOD;
  localparam longint unsigned WRAP_OFFS = WRAP_K * PERIOD - (64'd1 << (ANGLE_W - 1));

  // Interpolation datapath widths
  localparam int W_W    = 17;                 // weight, up to a bit above 1.0
  localparam int PROD_W = 2 * VALUE_W;
  localparam int SUM_W  = VALUE_W + 2;

  localparam int ONE_Q16 = 65536;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic        [W_W-1:0]     weight_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

endpackage

`default_nettype wire

FILE: src/scl_if.sv
// ============================================================================
// scl_in_if / scl_out_if
// Valid/ready channels for angle requests and interpolated results.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface scl_in_if;
  import scl_pkg::*;
  logic   valid;
  logic   ready;
  logic   op;
  angle_t angle;
  modport source (output valid, op, angle, input ready);
  modport sink   (input valid, op, angle, output ready);
endinterface

interface scl_out_if;
  import scl_pkg::*;
  logic   valid;
  logic   ready;
  value_t value;
  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

`default_nettype wire

FILE: src/sin_cos_lut_interpolator_top.sv
// ============================================================================
// sin_cos_lut_interpolator_top
// Sine or cosine of a Q16.16 angle by table lookup and linear interpolation.
// ============================================================================
// Usage:
//   in_ch  : one transaction per angle; op selects sine (0) or cosine (1),
//            angle is signed Q16.16 radians, any value (wrapped by floor
//            modulo the truncated 2*pi period).
//   out_ch : one transaction per input, value signed Q2.16 clamped to +-1.0,
//            in input order.
//   A transaction passes through 20 register stages on its way to
//   out_ch.valid: the input register loaded at acceptance, four constant
//   dividers of three stages each (period wrap, segment index, segment base,
//   interpolation weight), three single-stage glue registers, three
//   interpolation stages (ROM read, multiply, sum) and the output register.
//   Throughput is one transaction per cycle while the receiver does not stall.
//   The ROM holds 2*TABLE_ENTRIES constant entries; no fill is needed after
//   reset. Reset clears all valid bits; nothing is pending afterwards.
//   When the receiver stalls, the pipeline keeps advancing until its last
//   stage holds a result behind the output register; then the whole pipe
//   holds and in_ch.ready drops until out_ch.ready returns.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sin_cos_lut_interpolator_top #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  scl_in_if.sink          in_ch,
  scl_out_if.source       out_ch
);
  import scl_pkg::*;

  localparam int              SEG_W = $clog2(TABLE_ENTRIES);
  localparam longint unsigned SPAN  = PERIOD / TABLE_ENTRIES;
  localparam int              AN_W  = $clog2(PERIOD * TABLE_ENTRIES);
  localparam int              OFF_W = $clog2(SPAN + 64'd2);
  localparam int              DX_W  = OFF_W + FRAC_W;

  logic en;

  // Input register: angle made non-negative by a whole number of periods
  logic           u_v_r, u_op_r;
  logic [U_W-1:0] u_r, u_nxt;

  assign u_nxt = U_W'({~in_ch.angle[ANGLE_W-1], in_ch.angle[ANGLE_W-2:0]})
               + U_W'(WRAP_OFFS);

  always_ff @(posedge clk) begin
    if (!rst_n)  u_v_r <= 1'b0;
    else if (en) u_v_r <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r    <= u_nxt;
      u_op_r <= in_ch.op;
    end
  end

  // Wrap into [0, PERIOD)
  logic           a_v;
  logic           a_op;
  logic [A_W-1:0] a_val;

  scl_cdiv #(.XW(U_W), .DIV(PERIOD), .QW(1), .SW(1)) u_div_wrap (
    .clk, .rst_n, .en,
    .v_i(u_v_r), .x_i(u_r), .side_i(u_op_r),
    .v_o(a_v), .q_o(), .r_o(a_val), .side_o(a_op)
  );

  // Scale by table size
  logic            an_v_r, an_op_r;
  logic [A_W-1:0]  an_a_r;
  logic [AN_W-1:0] an_r, an_nxt;

  assign an_nxt = AN_W'(a_val) * AN_W'(TABLE_ENTRIES);

  always_ff @(posedge clk) begin
    if (!rst_n)  an_v_r <= 1'b0;
    else if (en) an_v_r <= a_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      an_r    <= an_nxt;
      an_a_r  <= a_val;
      an_op_r <= a_op;
    end
  end

  // Segment index
  logic             sg_v, sg_op;
  logic [A_W-1:0]   sg_a;
  logic [SEG_W-1:0] sg_seg;

  scl_cdiv #(.XW(AN_W), .DIV(PERIOD), .QW(SEG_W), .SW(1 + A_W)) u_div_seg (
    .clk, .rst_n, .en,
    .v_i(an_v_r), .x_i(an_r), .side_i({an_op_r, an_a_r}),
    .v_o(sg_v), .q_o(sg_seg), .r_o(), .side_o({sg_op, sg_a})
  );

  // Segment base numerator
  logic             sp_v_r, sp_op_r;
  logic [A_W-1:0]   sp_a_r;
  logic [SEG_W-1:0] sp_seg_r;
  logic [AN_W-1:0]  sp_r, sp_nxt;

  assign sp_nxt = AN_W'(sg_seg) * AN_W'(PERIOD);

  always_ff @(posedge clk) begin
    if (!rst_n)  sp_v_r <= 1'b0;
    else if (en) sp_v_r <= sg_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp_r     <= sp_nxt;
      sp_a_r   <= sg_a;
      sp_op_r  <= sg_op;
      sp_seg_r <= sg_seg;
    end
  end

  // Segment base angle
  logic             bs_v, bs_op;
  logic [A_W-1:0]   bs_a, bs_base;
  logic [SEG_W-1:0] bs_seg;

  scl_cdiv #(.XW(AN_W), .DIV(TABLE_ENTRIES), .QW(A_W), .SW(1 + A_W + SEG_W)) u_div_base (
    .clk, .rst_n, .en,
    .v_i(sp_v_r), .x_i(sp_r), .side_i({sp_op_r, sp_a_r, sp_seg_r}),
    .v_o(bs_v), .q_o(bs_base), .r_o(), .side_o({bs_op, bs_a, bs_seg})
  );

  // Offset inside the segment, at most one past the span
  logic             off_v_r, off_op_r;
  logic [SEG_W-1:0] off_seg_r;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [A_W-1:0]   off_diff;

  assign off_diff = bs_a - bs_base;
  assign off_nxt  = OFF_W'(off_diff);

  always_ff @(posedge clk) begin
    if (!rst_n)  off_v_r <= 1'b0;
    else if (en) off_v_r <= bs_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off_r     <= off_nxt;
      off_op_r  <= bs_op;
      off_seg_r <= bs_seg;
    end
  end

  // Interpolation weight
  logic             wt_v, wt_op;
  logic [SEG_W-1:0] wt_seg;
  weight_t          wt_w;

  scl_cdiv #(.XW(DX_W), .DIV(SPAN), .QW(W_W), .SW(1 + SEG_W)) u_div_wt (
    .clk, .rst_n, .en,
    .v_i(off_v_r), .x_i({off_r, {FRAC_W{1'b0}}}), .side_i({off_op_r, off_seg_r}),
    .v_o(wt_v), .q_o(wt_w), .r_o(), .side_o({wt_op, wt_seg})
  );

  // Table read and blend
  logic last_v;
  sum_t last_sum;

  scl_interp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_interp (
    .clk, .rst_n, .en,
    .v_i(wt_v), .op_i(wt_op), .seg_i(wt_seg), .w_i(wt_w),
    .v_o(last_v), .sum_o(last_sum)
  );

  // Output register with clamp
  logic   out_valid_r;
  value_t value_r, value_nxt;
  logic   out_load;

  always_comb begin
    if (last_sum > sum_t'(ONE_Q16))       value_nxt = value_t'(ONE_Q16);
    else if (last_sum < -sum_t'(ONE_Q16)) value_nxt = -value_t'(ONE_Q16);
    else                                  value_nxt = VALUE_W'(last_sum);
  end

  assign out_load = out_ch.ready || !out_valid_r;
  // Pipe moves unless a finished result is blocked behind a full output
  assign en       = out_load || !last_v;

  always_ff @(posedge clk) begin
    if (!rst_n)        out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= last_v;
  end

  always_ff @(posedge clk) begin
    if (out_load) value_r <= value_nxt;
  end

  assign in_ch.ready   = en;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = value_r;

  // Offset never exceeds the segment span by more than one
  a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
    off_v_r |-> (off_r <= OFF_W'(SPAN + 64'd1)))
    else $error("top: segment offset out of range");

  // Delivered value lies within +-1.0
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (value_r <= value_t'(ONE_Q16) && value_r >= -value_t'(ONE_Q16)))
    else $error("top: output value outside clamp range");

  // A blocked result freezes the whole pipe
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready && last_v) |=> ($stable(last_sum) && last_v))
    else $error("top: result lost while output stalled");

endmodule

`default_nettype wire

FILE: src/scl_cdiv.sv
// ============================================================================
// scl_cdiv
// Three-stage divider by a constant: reciprocal multiply, back-multiply and
// subtract, one correction step. Carries a sideband word along.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module scl_cdiv #(
  parameter int              XW  = 32,
  parameter longint unsigned DIV = 64'd402,
  parameter int              QW  = 8,
  parameter int              SW  = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    v_i,
  input  logic [XW-1:0]           x_i,
  input  logic [SW-1:0]           side_i,
  output logic                    v_o,
  output logic [QW-1:0]           q_o,
  output logic [$clog2(DIV)-1:0]  r_o,
  output logic [SW-1:0]           side_o
);
  import scl_pkg::*;

  localparam int              RW  = $clog2(DIV);
  // floor(2^XW / DIV): estimate is the quotient or one below it
  localparam longint unsigned MR  = (64'd1 << XW) / DIV;
  localparam int              MRW = $clog2(MR + 64'd1);
  localparam int              PW  = XW + MRW;

  logic          v1_r, v2_r, v3_r;
  logic [XW-1:0] x1_r;
  logic [SW-1:0] s1_r, s2_r, s3_r;
  logic [PW-1:0] prod1_r, prod1_nxt;
  logic [MRW-1:0] q2_r, q2_nxt, q3_r, q3_nxt;
  logic [RW:0]    r2_r, r2_nxt;
  logic [RW-1:0]  r3_r, r3_nxt;
  logic [XW-1:0]  back_mul;
  logic [XW-1:0]  rem_full;
  logic           fix;

  // Stage 1: reciprocal product
  assign prod1_nxt = PW'(x_i) * PW'(MR);

  // Stage 2: quotient estimate and remainder below twice the divisor
  assign q2_nxt   = prod1_r[XW +: MRW];
  assign back_mul = XW'(q2_nxt) * XW'(DIV);
  assign rem_full = x1_r - back_mul;
  assign r2_nxt   = rem_full[RW:0];

  // Stage 3: one correction step
  assign fix    = (r2_r >= (RW+1)'(DIV));
  assign q3_nxt = fix ? q2_r + MRW'(1) : q2_r;
  assign r3_nxt = fix ? RW'(r2_r - (RW+1)'(DIV)) : RW'(r2_r);

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= x_i;
      s1_r    <= side_i;
      prod1_r <= prod1_nxt;
      q2_r    <= q2_nxt;
      r2_r    <= r2_nxt;
      s2_r    <= s1_r;
      q3_r    <= q3_nxt;
      r3_r    <= r3_nxt;
      s3_r    <= s2_r;
    end
  end

  assign v_o    = v3_r;
  assign q_o    = QW'(q3_r);
  assign r_o    = r3_r;
  assign side_o = s3_r;

  // Reciprocal estimate is never more than one short
  a_est_range: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> ({1'b0, r2_r} < (RW+2)'(2 * DIV)))
    else $error("scl_cdiv: remainder estimate out of range");

  // Corrected remainder lies below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> ({1'b0, r3_r} < (RW+1)'(DIV)))
    else $error("scl_cdiv: remainder not below divisor");

endmodule

`default_nettype wire

FILE: src/scl_interp.sv
// ============================================================================
// scl_interp
// Sine/cosine ROM with registered two-address read, weight multiply and
// shifted sum of the two neighbors.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module scl_interp #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              v_i,
  input  logic                              op_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]  seg_i,
  input  scl_pkg::weight_t                  w_i,
  output logic                              v_o,
  output scl_pkg::sum_t                     sum_o
);
  import scl_pkg::*;

  localparam int              SEG_W       = $clog2(TABLE_ENTRIES);
  localparam int              AW          = $clog2(2 * TABLE_ENTRIES);
  localparam int              FRAC30      = 30;
  localparam longint unsigned ONE_Q30     = 64'd1 << FRAC30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef value_t rom_t [2*TABLE_ENTRIES];

  // Shift-and-subtract quotient, used only while building the table
  function automatic longint unsigned udiv_q(longint unsigned num, longint unsigned den);
    longint unsigned q, r;
    q = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((num >> b) & 64'd1);
      if (r >= den) begin
        r = r - den;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // Taylor series on [0, pi/2) in Q2.30; odd selects sine
  function automatic longint unsigned series_q30(longint unsigned x, bit odd);
    longint unsigned term, pos, neg, k;
    term = odd ? x : ONE_Q30;
    pos  = term;
    neg  = 64'd0;
    k    = odd ? 64'd2 : 64'd1;
    for (int n = 0; n < 16; n++) begin
      term = (term * x) >> FRAC30;
      term = (term * x) >> FRAC30;
      term = udiv_q(term, k * (k + 64'd1));
      k    = k + 64'd2;
      if ((n & 1) != 0) pos = pos + term;
      else              neg = neg + term;
    end
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  // Q2.30 magnitude to Q2.16, round half away from zero
  function automatic value_t to_q16(longint unsigned mag, bit negative);
    value_t v;
    v = VALUE_W'((mag + 64'd8192) >> 14);
    return negative ? -v : v;
  endfunction

  // Lower half sine, upper half cosine
  function automatic rom_t build_rom();
    rom_t            tbl;
    longint unsigned quad, rem, x, s, c;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      quad = (64'd4 * longint'(i)) / TABLE_ENTRIES;
      rem  = 64'd4 * longint'(i) - quad * TABLE_ENTRIES;
      x    = HALF_PI_Q30 * rem / TABLE_ENTRIES;
      s    = series_q30(x, 1'b1);
      c    = series_q30(x, 1'b0);
      case (quad & 64'd3)
        64'd0: begin
          tbl[i] = to_q16(s, 1'b0); tbl[i+TABLE_ENTRIES] = to_q16(c, 1'b0);
        end
        64'd1: begin
          tbl[i] = to_q16(c, 1'b0); tbl[i+TABLE_ENTRIES] = to_q16(s, 1'b1);
        end
        64'd2: begin
          tbl[i] = to_q16(s, 1'b1); tbl[i+TABLE_ENTRIES] = to_q16(c, 1'b1);
        end
        default: begin
          tbl[i] = to_q16(c, 1'b1); tbl[i+TABLE_ENTRIES] = to_q16(s, 1'b0);
        end
      endcase
    end
    return tbl;
  endfunction

  localparam rom_t ROM_TBL = build_rom();

  logic [SEG_W-1:0] seg_hi;
  logic [AW-1:0]    addr_lo_nxt, addr_hi_nxt;
  logic             v1_r, v2_r, v3_r;
  value_t           lo_r, hi_r;
  weight_t          w1_r;
  value_t           wlo, whi;
  prod_t            p0_r, p0_nxt, p1_r, p1_nxt;
  sum_t             sum_r, sum_nxt;

  // Upper neighbor wraps to entry zero
  assign seg_hi      = (seg_i == SEG_W'(TABLE_ENTRIES - 1)) ? '0 : seg_i + SEG_W'(1);
  assign addr_lo_nxt = op_i ? AW'(TABLE_ENTRIES) + AW'(seg_i)  : AW'(seg_i);
  assign addr_hi_nxt = op_i ? AW'(TABLE_ENTRIES) + AW'(seg_hi) : AW'(seg_hi);

  // Weights: 1-t may go negative when t runs past 1.0
  assign whi    = $signed({1'b0, w1_r});
  assign wlo    = value_t'(ONE_Q16) - whi;
  assign p0_nxt = PROD_W'(lo_r) * PROD_W'(wlo);
  assign p1_nxt = PROD_W'(hi_r) * PROD_W'(whi);

  // Floor shift of each product, then sum
  assign sum_nxt = SUM_W'(p0_r >>> FRAC_W) + SUM_W'(p1_r >>> FRAC_W);

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // ROM read and datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      lo_r  <= ROM_TBL[addr_lo_nxt];
      hi_r  <= ROM_TBL[addr_hi_nxt];
      w1_r  <= w_i;
      p0_r  <= p0_nxt;
      p1_r  <= p1_nxt;
      sum_r <= sum_nxt;
    end
  end

  assign v_o   = v3_r;
  assign sum_o = sum_r;

  // Table entries stay within +-1.0
  a_rom_range: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (lo_r <= value_t'(ONE_Q16) && lo_r >= -value_t'(ONE_Q16)
              && hi_r <= value_t'(ONE_Q16) && hi_r >= -value_t'(ONE_Q16)))
    else $error("scl_interp: table entry out of range");

  // Weight never runs far past 1.0
  a_weight: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (w1_r < W_W'(2 * ONE_Q16 - 1) && w1_r[W_W-1:FRAC_W] <= 1'b1))
    else $error("scl_interp: weight out of range");

  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (sum_r < sum_t'(3 * ONE_Q16) && sum_r > -sum_t'(3 * ONE_Q16)))
    else $error("scl_interp: sum far out of range");

endmodule

`default_nettype wire
